### design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/rrst_pkg.sv
package rrst_pkg;

  localparam int LEAVES = 1024;

  function automatic int pad_of(input int n);
    int p;
    p = 1;
    while (p < n) p = p << 1;
    return p;
  endfunction

  localparam int PAD       = pad_of(LEAVES);
  localparam int LVL       = $clog2(PAD);
  localparam int HW        = LVL + 1;                 // heap index width, node 1 is the root
  localparam int DW        = $clog2(LVL + 2);         // depth and shift counts
  localparam int NID_W     = $clog2(4 * LVL + 2);     // count of empty sub-ranges seen
  localparam int DATA_W    = 32;
  localparam int OPC_W     = 2;
  localparam int IDX_W     = 10;
  localparam int RANGE_W   = 11;
  localparam int MODE_W    = 2;
  localparam int CW        = (HW > RANGE_W) ? HW : RANGE_W;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [OPC_W-1:0] {
    OP_WRITE = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  localparam logic [MODE_W-1:0] MODE_MIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SUM = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MERGE_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDENTITY   = 1'd1;

  // Signed min, signed max, or wrapping sum for any other mode code.
  function automatic logic [DATA_W-1:0] combine(input logic [MODE_W-1:0] mode,
                                                input logic [DATA_W-1:0] x,
                                                input logic [DATA_W-1:0] y);
    case (mode)
      MODE_MIN: return ($signed(x) <= $signed(y)) ? x : y;
      MODE_MAX: return ($signed(x) >= $signed(y)) ? x : y;
      default:  return x + y;
    endcase
  endfunction

endpackage

### design/range_reduce_segment_tree_unit.sv
// Channel   Handshake            Payload
// request   start / busy         in_opcode, in_leaf_index, in_leaf_value,
//                                in_range_start, in_range_end
// result    out_valid (strobe)   out_reduced_value
// config    cfg_we               cfg_index, cfg_data
//
// Request flow, from the accepting edge until the unit can accept again:
// write climbs one tree level per cycle through the node memory's read and write ports;
// query walks the tree, visiting at most 4*LVL+1 nodes, with the result strobe
// in the first idle cycle; clear fills the node memory one node per cycle.
// After reset all 2*PAD nodes (2048) of the node memory are swept to zero with busy high.
// Busy stays high for the whole of a request; results cannot be held off.
module range_reduce_segment_tree_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [rrst_pkg::OPC_W-1:0]             in_opcode,
  input  logic [rrst_pkg::IDX_W-1:0]             in_leaf_index,
  input  logic signed [rrst_pkg::DATA_W-1:0]     in_leaf_value,
  input  logic [rrst_pkg::RANGE_W-1:0]           in_range_start,
  input  logic [rrst_pkg::RANGE_W-1:0]           in_range_end,
  output logic                                   out_valid,
  output logic signed [rrst_pkg::DATA_W-1:0]     out_reduced_value,
  input  logic                                   cfg_we,
  input  logic [rrst_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [rrst_pkg::DATA_W-1:0]            cfg_data
);

  import rrst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_WUP,
    S_QWALK,
    S_QMUL,
    S_QOUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [DATA_W-1:0]   ident_r, ident_nxt;
  logic [DATA_W-1:0]   fill_r, fill_nxt;
  logic [HW-1:0]       cnt_r, cnt_nxt;
  logic [HW-1:0]       h_r, h_nxt;
  logic [DW-1:0]       d_r, d_nxt;
  logic [DATA_W-1:0]   cur_r, cur_nxt;
  logic [DATA_W-1:0]   acc_r, acc_nxt;
  logic                have_r, have_nxt;
  logic                pend_r, pend_nxt;
  logic [NID_W-1:0]    nid_r, nid_nxt;
  logic [RANGE_W-1:0]  a_r, a_nxt;
  logic [RANGE_W-1:0]  b_r, b_nxt;
  logic [DATA_W-1:0]   idt_r, idt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_val_r, out_val_nxt;

  logic                mem_we;
  logic [HW-1:0]       mem_waddr;
  logic [DATA_W-1:0]   mem_wdata;
  logic [HW-1:0]       mem_raddr;
  logic [DATA_W-1:0]   mem_rdata;

  // Node interval and preorder successor for the query walk
  logic [HW-1:0]       node_off;
  logic [DW-1:0]       node_sh;
  logic [CW-1:0]       node_l, node_r;
  logic [CW-1:0]       a_x, b_x;
  logic                disj, cont;
  logic [DW-1:0]       t_ones;
  logic [HW-1:0]       h_up;
  logic                walk_done;
  logic [HW-1:0]       h_leaf;
  logic [HW-1:0]       h_par;
  logic [DATA_W-1:0]   up_val;

  rrst_ram #(
    .WIDTH(DATA_W),
    .DEPTH(2 * PAD)
  ) u_nodes (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    node_off = h_r ^ (HW'(1) << d_r);
    node_sh  = DW'(LVL) - d_r;
    node_l   = CW'(node_off) << node_sh;
    node_r   = node_l + (CW'(PAD) >> d_r);
    a_x      = CW'(a_r);
    b_x      = CW'(b_r);
    disj     = (node_r <= a_x) || (b_x <= node_l);
    cont     = (a_x <= node_l) && (node_r <= b_x);
    // lowest clear bit of the heap index: climb out of finished right children
    t_ones = DW'(HW);
    for (int i = HW - 1; i >= 0; i--) begin
      if (!h_r[i]) t_ones = DW'(i);
    end
    h_up      = h_r >> t_ones;
    walk_done = (h_up == '0);
    h_leaf    = HW'(PAD) | HW'(in_leaf_index);
    h_par     = h_r >> 1;
    up_val    = combine(mode_r, cur_r, mem_rdata);
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    ident_nxt     = ident_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    h_nxt         = h_r;
    d_nxt         = d_r;
    cur_nxt       = cur_r;
    acc_nxt       = acc_r;
    have_nxt      = have_r;
    pend_nxt      = 1'b0;
    nid_nxt       = nid_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    idt_nxt       = idt_r;
    out_valid_nxt = 1'b0;
    out_val_nxt   = out_val_r;
    mem_we        = 1'b0;
    mem_waddr     = h_r;
    mem_wdata     = cur_r;
    mem_raddr     = h_r;

    if (cfg_we) begin
      case (cfg_index)
        REG_MERGE_MODE: mode_nxt  = cfg_data[MODE_W-1:0];
        REG_IDENTITY:   ident_nxt = cfg_data;
        default:        ;
      endcase
    end

    // fold in a node read issued by the walk in the previous cycle
    if (pend_r) begin
      acc_nxt  = have_r ? combine(mode_r, acc_r, mem_rdata) : mem_rdata;
      have_nxt = 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (op_t'(in_opcode))
            OP_WRITE: begin
              if (32'(in_leaf_index) < 32'(LEAVES)) begin
                mem_we    = 1'b1;
                mem_waddr = h_leaf;
                mem_wdata = in_leaf_value;
                mem_raddr = h_leaf ^ HW'(1);
                cur_nxt   = in_leaf_value;
                h_nxt     = h_leaf;
                state_nxt = S_WUP;
              end
            end
            OP_QUERY: begin
              a_nxt     = in_range_start;
              b_nxt     = in_range_end;
              h_nxt     = HW'(1);
              d_nxt     = '0;
              have_nxt  = 1'b0;
              nid_nxt   = '0;
              state_nxt = S_QWALK;
            end
            OP_CLEAR: begin
              fill_nxt  = ident_r;
              cnt_nxt   = '0;
              state_nxt = S_SWEEP;
            end
            default: ;
          endcase
        end
      end
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = fill_r;
        cnt_nxt   = cnt_r + HW'(1);
        if (cnt_r == '1) state_nxt = S_IDLE;
      end
      S_WUP: begin
        // sibling arrives now: write the parent and fetch the parent's sibling
        mem_we    = 1'b1;
        mem_waddr = h_par;
        mem_wdata = up_val;
        mem_raddr = h_par ^ HW'(1);
        cur_nxt   = up_val;
        h_nxt     = h_par;
        if (h_par == HW'(1)) state_nxt = S_IDLE;
      end
      S_QWALK: begin
        if (cont) begin
          mem_raddr = h_r;
          pend_nxt  = 1'b1;
        end else if (disj) begin
          nid_nxt = nid_r + NID_W'(1);
        end
        if (!cont && !disj) begin
          h_nxt = h_r << 1;
          d_nxt = d_r + DW'(1);
        end else if (walk_done) begin
          state_nxt = S_QMUL;
        end else begin
          h_nxt = h_up + HW'(1);
          d_nxt = d_r - t_ones;
        end
      end
      S_QMUL: begin
        // every empty sub-range contributes the identity once
        if (mode_r == MODE_MIN || mode_r == MODE_MAX) begin
          idt_nxt = ident_r;
        end else begin
          idt_nxt = DATA_W'(ident_r * DATA_W'(nid_r));
        end
        state_nxt = S_QOUT;
      end
      S_QOUT: begin
        if (!have_r) begin
          out_val_nxt = idt_r;
        end else if (nid_r != '0) begin
          out_val_nxt = combine(mode_r, acc_r, idt_r);
        end else begin
          out_val_nxt = acc_r;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      mode_r      <= MODE_SUM;
      ident_r     <= '0;
      fill_r      <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      ident_r     <= ident_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
    h_r       <= h_nxt;
    d_r       <= d_nxt;
    cur_r     <= cur_nxt;
    acc_r     <= acc_nxt;
    nid_r     <= nid_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    idt_r     <= idt_nxt;
    out_val_r <= out_val_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_reduced_value = out_val_r;

endmodule

### design/rrst_ram.sv
module rrst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/rrst_checker.sv
`include "assert_macros.svh"

module rrst_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic [rrst_pkg::OPC_W-1:0]         in_opcode,
  input logic                               out_valid
);

  import rrst_pkg::*;

  logic q_req;
  logic nq_req;

  assign q_req  = start && !busy && (in_opcode == OP_QUERY);
  assign nq_req = start && !busy && (in_opcode != OP_QUERY);

  `ASSERT_CLK(a_reset_sweep, clk, (rst_n && !$past(rst_n)) |-> busy, "no sweep after reset")
  `ASSERT_CLK_RST(a_query_busy, clk, rst_n, q_req |=> busy, "query request did not hold busy")
  `ASSERT_CLK_RST(a_result_idle, clk, rst_n, out_valid |-> !busy, "result shown while busy")
  `ASSERT_CLK_RST(a_result_single, clk, rst_n, out_valid |=> !out_valid, "result repeated")
  `ASSERT_CLK_RST(a_no_result_nq, clk, rst_n, nq_req |=> !out_valid, "result from non-query")

endmodule

bind range_reduce_segment_tree_unit rrst_checker u_rrst_checker (.*);
